FILE: src/pfsc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// pfsc_pkg
// Shared widths, register indexes and reset values of the fan-speed PI core.
// ============================================================================
package pfsc_pkg;

    localparam int DEFAULT_FRAC_BITS = 16;

    // Integral term storage width (signed).
    localparam int INT_W = 40;

    // Field widths.
    localparam int TEMP_W = 8;
    localparam int FAN_W  = 7;
    localparam int GAIN_W = 16;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;

    // Shared multiplier operand widths (signed).
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Error width: temperature minus target, signed.
    localparam int ERR_W = TEMP_W + 1;

    typedef enum logic [IDX_W-1:0] {
        REG_TARGET_TEMP = 3'd0,
        REG_MIN_FAN     = 3'd1,
        REG_MAX_FAN     = 3'd2,
        REG_PROP_GAIN   = 3'd3,
        REG_INT_GAIN    = 3'd4,
        REG_TIME_STEP   = 3'd5
    } cfg_index_t;

    localparam logic [TEMP_W-1:0] RST_TARGET_TEMP = 8'd60;
    localparam logic [FAN_W-1:0]  RST_MIN_FAN     = 7'd30;
    localparam logic [FAN_W-1:0]  RST_MAX_FAN     = 7'd100;
    localparam logic [GAIN_W-1:0] RST_PROP_GAIN   = 16'd512;
    localparam logic [GAIN_W-1:0] RST_INT_GAIN    = 16'd26;
    localparam logic [GAIN_W-1:0] RST_TIME_STEP   = 16'd256;

endpackage

FILE: src/pfsc_arith.sv
`timescale 1ns / 1ps
// ============================================================================
// pfsc_arith
// Shared arithmetic unit: one signed multiplier and one add/subtract stage,
// reused by the sequencer for every product and sum of a step.
// ============================================================================
module pfsc_arith
    import pfsc_pkg::*;
#(
    parameter int ACC_W = 44
)
(
    input  logic signed [MUL_A_W-1:0] mul_a,
    input  logic signed [MUL_B_W-1:0] mul_b,
    output logic signed [MUL_P_W-1:0] prod,
    input  logic signed [ACC_W-1:0]   add_a,
    input  logic signed [ACC_W-1:0]   add_b,
    input  logic                      add_sub,
    output logic signed [ACC_W-1:0]   sum
);

    logic signed [ACC_W-1:0] b_eff;

    assign prod  = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    // Two's complement subtract: invert the second operand and carry in one.
    assign b_eff = add_sub ? ~add_b : add_b;
    assign sum   = add_a + b_eff + ACC_W'({1'b0, add_sub});

endmodule

FILE: src/pi_fan_speed_controller_core.sv
`timescale 1ns / 1ps
// ============================================================================
// pi_fan_speed_controller_core
// PI fan-speed regulator with back-calculation anti-windup and bumpless seed.
// ============================================================================
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+---------------------------------
//  in       | input     | in_valid / in_stall   | kind, temperature, present_fan
//  out      | output    | out_valid / out_stall | fan_speed
//  cfg      | input     | cfg_we (no wait)      | cfg_index, cfg_data
//
// A regulation beat runs the multiplies, integral update, output sums, limit checks
// (the lower one skipped when the upper limit clips) and rounding, a seed beat the
// multiplies and seed states. One multiplier and one adder serve every step.
// in_stall is high from acceptance until the result is handed to the output
// register; the hand-over waits while that register holds a stalled beat.
// Reset (rst_n low, asynchronous) loads the register defaults and clears the integral.
// ============================================================================
module pi_fan_speed_controller_core
    import pfsc_pkg::*;
#(
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              kind,
    input  logic [TEMP_W-1:0] temperature,
    input  logic [FAN_W-1:0]  present_fan,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [FAN_W-1:0]  fan_speed,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam int ACC_W   = (FRAC_BITS + 28 > 44) ? FRAC_BITS + 28 : 44;
    localparam int INC_SHL = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int INC_SHR = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int P_SHL   = FRAC_BITS - 8;

    localparam logic signed [ACC_W-1:0] LIM_HI =
        {{(ACC_W-INT_W+1){1'b0}}, {(INT_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] LIM_LO =
        {{(ACC_W-INT_W+1){1'b1}}, {(INT_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_GT,
        S_MUL_INC,
        S_MUL_P,
        S_INT_ADD,
        S_OUT_BASE,
        S_OUT_INT,
        S_CHK_HI,
        S_FIX_HI,
        S_CHK_LO,
        S_FIX_LO,
        S_ROUND,
        S_SEED_A,
        S_SEED_B,
        S_SEED_C,
        S_DONE
    } state_t;

    function automatic logic signed [INT_W-1:0] sat_int(input logic signed [ACC_W-1:0] v);
        logic signed [INT_W-1:0] r;
        if (v > LIM_HI)
            r = LIM_HI[INT_W-1:0];
        else if (v < LIM_LO)
            r = LIM_LO[INT_W-1:0];
        else
            r = v[INT_W-1:0];
        return r;
    endfunction

    // Control and configuration registers.
    state_t              state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic [FAN_W-1:0]    fan_speed_reg, fan_speed_next;
    logic [TEMP_W-1:0]   target_reg;
    logic [FAN_W-1:0]    min_fan_reg;
    logic [FAN_W-1:0]    max_fan_reg;
    logic [GAIN_W-1:0]   prop_gain_reg;
    logic [GAIN_W-1:0]   int_gain_reg;
    logic [GAIN_W-1:0]   time_step_reg;
    logic signed [INT_W-1:0] integral_reg, integral_next;

    // Working registers of one beat.
    logic                    kind_reg, kind_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic [FAN_W-1:0]        present_reg, present_next;
    logic [31:0]             igts_reg, igts_next;
    logic signed [ACC_W-1:0] inc_reg, inc_next;
    logic signed [ACC_W-1:0] p_reg, p_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] diff_reg, diff_next;
    logic [FAN_W-1:0]        result_reg, result_next;

    // Shared unit operands.
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;
    logic signed [ACC_W-1:0]   add_a;
    logic signed [ACC_W-1:0]   add_b;
    logic                      add_sub;
    logic signed [ACC_W-1:0]   sum;

    logic signed [ACC_W-1:0] integ_ext;
    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W-1:0] upper;
    logic signed [ACC_W-1:0] present_scaled;
    logic signed [ACC_W-1:0] prod_ext;
    logic                    int_off;
    logic                    in_accept;

    pfsc_arith #(
        .ACC_W (ACC_W)
    ) u_arith (
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .prod    (prod),
        .add_a   (add_a),
        .add_b   (add_b),
        .add_sub (add_sub),
        .sum     (sum)
    );

    assign integ_ext      = {{(ACC_W-INT_W){integral_reg[INT_W-1]}}, integral_reg};
    assign base           = ACC_W'(min_fan_reg) << FRAC_BITS;
    assign upper          = ACC_W'(max_fan_reg) << FRAC_BITS;
    assign present_scaled = ACC_W'(present_reg) << FRAC_BITS;
    assign prod_ext       = ACC_W'(prod);
    assign int_off        = (int_gain_reg == '0);
    assign in_accept      = in_valid && !in_stall;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign fan_speed = fan_speed_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        fan_speed_next = fan_speed_reg;
        integral_next  = integral_reg;
        kind_next      = kind_reg;
        err_next       = err_reg;
        present_next   = present_reg;
        igts_next      = igts_reg;
        inc_next       = inc_reg;
        p_next         = p_reg;
        acc_next       = acc_reg;
        diff_next      = diff_reg;
        result_next    = result_reg;

        mul_a   = '0;
        mul_b   = '0;
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next    = kind;
                    present_next = present_fan;
                    err_next     = ERR_W'({1'b0, temperature}) - ERR_W'({1'b0, target_reg});
                    state_next   = S_MUL_GT;
                end
            end
            S_MUL_GT:
            begin
                mul_a      = MUL_A_W'({1'b0, time_step_reg});
                mul_b      = MUL_B_W'({1'b0, int_gain_reg});
                igts_next  = prod[31:0];
                state_next = S_MUL_INC;
            end
            S_MUL_INC:
            begin
                mul_a      = MUL_A_W'({1'b0, igts_reg});
                mul_b      = MUL_B_W'(err_reg);
                // Q.16 increment brought to the integral's fraction, floored.
                inc_next   = (prod_ext <<< INC_SHL) >>> INC_SHR;
                state_next = S_MUL_P;
            end
            S_MUL_P:
            begin
                mul_a      = MUL_A_W'(err_reg);
                mul_b      = MUL_B_W'({1'b0, prop_gain_reg});
                p_next     = prod_ext <<< P_SHL;
                state_next = kind_reg ? S_INT_ADD : S_SEED_A;
            end
            S_INT_ADD:
            begin
                add_a         = integ_ext;
                add_b         = inc_reg;
                integral_next = int_off ? '0 : sat_int(sum);
                state_next    = S_OUT_BASE;
            end
            S_OUT_BASE:
            begin
                add_a      = base;
                add_b      = p_reg;
                acc_next   = sum;
                state_next = S_OUT_INT;
            end
            S_OUT_INT:
            begin
                add_a      = acc_reg;
                add_b      = integ_ext;
                acc_next   = sum;
                state_next = S_CHK_HI;
            end
            S_CHK_HI:
            begin
                add_a      = upper;
                add_b      = acc_reg;
                add_sub    = 1'b1;
                diff_next  = sum;
                state_next = S_FIX_HI;
            end
            S_FIX_HI:
            begin
                add_a = integ_ext;
                add_b = diff_reg;
                // A negative margin means the output is above the upper limit.
                if (diff_reg[ACC_W-1])
                begin
                    if (!int_off)
                        integral_next = sat_int(sum);
                    acc_next   = upper;
                    state_next = S_ROUND;
                end
                else
                begin
                    state_next = S_CHK_LO;
                end
            end
            S_CHK_LO:
            begin
                add_a      = base;
                add_b      = acc_reg;
                add_sub    = 1'b1;
                diff_next  = sum;
                state_next = S_FIX_LO;
            end
            S_FIX_LO:
            begin
                add_a = integ_ext;
                add_b = diff_reg;
                if (!diff_reg[ACC_W-1] && (diff_reg != '0))
                begin
                    if (!int_off)
                        integral_next = sat_int(sum);
                    acc_next = base;
                end
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                add_a       = acc_reg;
                add_b       = HALF;
                result_next = sum[FRAC_BITS +: FAN_W];
                state_next  = S_DONE;
            end
            S_SEED_A:
            begin
                add_a      = present_scaled;
                add_b      = base;
                add_sub    = 1'b1;
                acc_next   = sum;
                state_next = S_SEED_B;
            end
            S_SEED_B:
            begin
                add_a      = acc_reg;
                add_b      = p_reg;
                add_sub    = 1'b1;
                acc_next   = sum;
                state_next = S_SEED_C;
            end
            S_SEED_C:
            begin
                add_a         = acc_reg;
                add_b         = inc_reg;
                add_sub       = 1'b1;
                integral_next = int_off ? '0 : sat_int(sum);
                result_next   = present_reg;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                // Hand over once the output register is empty or being emptied.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    fan_speed_next = result_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            fan_speed_reg <= '0;
            integral_reg  <= '0;
            target_reg    <= RST_TARGET_TEMP;
            min_fan_reg   <= RST_MIN_FAN;
            max_fan_reg   <= RST_MAX_FAN;
            prop_gain_reg <= RST_PROP_GAIN;
            int_gain_reg  <= RST_INT_GAIN;
            time_step_reg <= RST_TIME_STEP;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            fan_speed_reg <= fan_speed_next;
            integral_reg  <= integral_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TARGET_TEMP: target_reg    <= cfg_data[TEMP_W-1:0];
                    REG_MIN_FAN:     min_fan_reg   <= cfg_data[FAN_W-1:0];
                    REG_MAX_FAN:     max_fan_reg   <= cfg_data[FAN_W-1:0];
                    REG_PROP_GAIN:   prop_gain_reg <= cfg_data[GAIN_W-1:0];
                    REG_INT_GAIN:    int_gain_reg  <= cfg_data[GAIN_W-1:0];
                    REG_TIME_STEP:   time_step_reg <= cfg_data[GAIN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        err_reg     <= err_next;
        present_reg <= present_next;
        igts_reg    <= igts_next;
        inc_reg     <= inc_next;
        p_reg       <= p_next;
        acc_reg     <= acc_next;
        diff_reg    <= diff_next;
        result_reg  <= result_next;
    end

    // An accepted beat always starts the multiply sequence.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_MUL_GT))
        else $error("accepted beat did not start the sequence");

    // With integral action off, the integral is zero after every update.
    a_int_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_INT_ADD || state_reg == S_SEED_C) && int_off)
        |=> (integral_reg == '0))
        else $error("integral not cleared with zero integral gain");

    // With an ordered range the value that is rounded lies within the limits.
    a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND && max_fan_reg >= min_fan_reg)
        |-> (acc_reg >= base && acc_reg <= upper))
        else $error("output not clamped before rounding");

    // A new result appears only when the sequencer hands one over.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("output valid raised outside hand-over");

endmodule

FILE: verif/tb_pi_fan_speed_controller_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_pi_fan_speed_controller_core
// Self-checking bench for the PI fan-speed core. A short table of directed
// beats (reset defaults, temperature extremes, seeding, integral off, max
// below min, integral saturation) is followed by random phases under
// changing register settings and idling patterns. Each accepted input beat
// is run through a fixed-point PI predictor and every output beat is
// compared against the oldest pending fan speed.
// ============================================================================
module tb_pi_fan_speed_controller_core;
    import pfsc_pkg::*;

    localparam int FRAC_BITS    = DEFAULT_FRAC_BITS;
    localparam int DIR_ROWS     = 29;
    localparam int PHASES       = 8;
    localparam int PHASE_BEATS  = 62;
    localparam int DRAIN_CYCLES = 32;

    localparam logic KIND_SEED = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        row_kind_t         op;
        logic              kind;
        logic [TEMP_W-1:0] temp;
        logic [FAN_W-1:0]  present;
        cfg_index_t        idx;
        logic [CFG_W-1:0]  data;
        logic              typed;
        logic [FAN_W-1:0]  fan;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              kind = 1'b0;
    logic [TEMP_W-1:0] temperature = '0;
    logic [FAN_W-1:0]  present_fan = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [FAN_W-1:0]  fan_speed;
    logic              cfg_we = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;

    idle_mode_t        idle_mode = IDLE_NONE;
    int                error_count = 0;
    logic [FAN_W-1:0]  fan_q [$];

    // Predictor copy of the registers and the integral term.
    logic [TEMP_W-1:0] m_target   = RST_TARGET_TEMP;
    logic [FAN_W-1:0]  m_min_fan  = RST_MIN_FAN;
    logic [FAN_W-1:0]  m_max_fan  = RST_MAX_FAN;
    logic [GAIN_W-1:0] m_prop     = RST_PROP_GAIN;
    logic [GAIN_W-1:0] m_int      = RST_INT_GAIN;
    logic [GAIN_W-1:0] m_step     = RST_TIME_STEP;
    longint            m_integral = 0;

    dir_row_t dir_table [DIR_ROWS] = '{
        '{ROW_ITEM, KIND_STEP, 8'd60,  7'd0,   REG_TARGET_TEMP, 16'd0,      1'b1, 7'd30},
        '{ROW_ITEM, KIND_STEP, 8'd255, 7'd0,   REG_TARGET_TEMP, 16'd0,      1'b1, 7'd100},
        '{ROW_ITEM, KIND_STEP, 8'd0,   7'd0,   REG_TARGET_TEMP, 16'd0,      1'b1, 7'd30},
        '{ROW_ITEM, KIND_SEED, 8'd60,  7'd0,   REG_TARGET_TEMP, 16'd0,      1'b1, 7'd0},
        '{ROW_ITEM, KIND_SEED, 8'd255, 7'd100, REG_TARGET_TEMP, 16'd0,      1'b1, 7'd100},
        '{ROW_ITEM, KIND_STEP, 8'd255, 7'd0,   REG_TARGET_TEMP, 16'd0,      1'b0, 7'd0},
        '{ROW_ITEM, KIND_SEED, 8'd70,  7'd77,  REG_TARGET_TEMP, 16'd0,      1'b1, 7'd77},
        '{ROW_ITEM, KIND_STEP, 8'd70,  7'd0,   REG_TARGET_TEMP, 16'd0,      1'b0, 7'd0},
        '{ROW_ITEM, KIND_STEP, 8'd62,  7'd0,   REG_TARGET_TEMP, 16'd0,      1'b0, 7'd0},
        '{ROW_CFG,  KIND_STEP, 8'd0,   7'd0,   REG_INT_GAIN,    16'd0,      1'b0, 7'd0},
        '{ROW_ITEM, KIND_STEP, 8'd80,  7'd0,   REG_TARGET_TEMP, 16'd0,      1'b0, 7'd0},
        '{ROW_ITEM, KIND_SEED, 8'd80,  7'd45,  REG_TARGET_TEMP, 16'd0,      1'b1, 7'd45},
        '{ROW_ITEM, KIND_STEP, 8'd61,  7'd0,   REG_TARGET_TEMP, 16'd0,      1'b0, 7'd0},
        '{ROW_CFG,  KIND_STEP, 8'd0,   7'd0,   REG_MIN_FAN,     16'd40,     1'b0, 7'd0},
        '{ROW_CFG,  KIND_STEP, 8'd0,   7'd0,   REG_MAX_FAN,     16'd20,     1'b0, 7'd0},
        '{ROW_ITEM, KIND_STEP, 8'd255, 7'd0,   REG_TARGET_TEMP, 16'd0,      1'b1, 7'd20},
        '{ROW_ITEM, KIND_STEP, 8'd0,   7'd0,   REG_TARGET_TEMP, 16'd0,      1'b1, 7'd40},
        '{ROW_ITEM, KIND_STEP, 8'd60,  7'd0,   REG_TARGET_TEMP, 16'd0,      1'b1, 7'd20},
        '{ROW_CFG,  KIND_STEP, 8'd0,   7'd0,   REG_MIN_FAN,     16'd0,      1'b0, 7'd0},
        '{ROW_CFG,  KIND_STEP, 8'd0,   7'd0,   REG_MAX_FAN,     16'd100,    1'b0, 7'd0},
        '{ROW_CFG,  KIND_STEP, 8'd0,   7'd0,   REG_TARGET_TEMP, 16'd0,      1'b0, 7'd0},
        '{ROW_CFG,  KIND_STEP, 8'd0,   7'd0,   REG_INT_GAIN,    16'hFFFF,   1'b0, 7'd0},
        '{ROW_CFG,  KIND_STEP, 8'd0,   7'd0,   REG_TIME_STEP,   16'hFFFF,   1'b0, 7'd0},
        '{ROW_CFG,  KIND_STEP, 8'd0,   7'd0,   REG_PROP_GAIN,   16'd0,      1'b0, 7'd0},
        '{ROW_ITEM, KIND_SEED, 8'd255, 7'd50,  REG_TARGET_TEMP, 16'd0,      1'b1, 7'd50},
        '{ROW_ITEM, KIND_STEP, 8'd255, 7'd0,   REG_TARGET_TEMP, 16'd0,      1'b0, 7'd0},
        '{ROW_ITEM, KIND_STEP, 8'd0,   7'd0,   REG_TARGET_TEMP, 16'd0,      1'b0, 7'd0},
        '{ROW_ITEM, KIND_STEP, 8'd255, 7'd0,   REG_TARGET_TEMP, 16'd0,      1'b0, 7'd0},
        '{ROW_ITEM, KIND_STEP, 8'd255, 7'd0,   REG_TARGET_TEMP, 16'd0,      1'b0, 7'd0}
    };

    pi_fan_speed_controller_core #(
        .FRAC_BITS   (FRAC_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .temperature (temperature),
        .present_fan (present_fan),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .fan_speed   (fan_speed),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic bit roll(input idle_mode_t own);
        int pct;
        pct = (idle_mode == own) ? 50 : ((idle_mode == IDLE_BOTH) ? 24 : 0);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic longint sat40(input longint v);
        longint lim;
        lim = longint'(1) << (INT_W - 1);
        if (v > lim - 1)
        begin
            return lim - 1;
        end
        if (v < -lim)
        begin
            return -lim;
        end
        return v;
    endfunction

    function automatic longint to_frac_q8(input longint v);
        return v * (longint'(1) << (FRAC_BITS - 8));
    endfunction

    // One PI update; returns the commanded fan speed and advances the integral.
    function automatic logic [FAN_W-1:0] predict_fan(input logic k,
                                                     input logic [TEMP_W-1:0] t,
                                                     input logic [FAN_W-1:0] pf);
        longint     err;
        longint     prop;
        longint     incr;
        longint     base;
        longint     upper;
        longint     outv;
        logic [31:0] gain_step;
        err       = longint'(t) - longint'(m_target);
        gain_step = 32'(m_int) * 32'(m_step);
        prop      = to_frac_q8(longint'(m_prop) * err);
        incr      = longint'(gain_step) * err;
        if (FRAC_BITS >= 16)
        begin
            incr = incr * (longint'(1) << (FRAC_BITS - 16));
        end
        else
        begin
            incr = incr >>> (16 - FRAC_BITS);
        end
        base  = to_frac_q8(longint'(m_min_fan) << 8);
        upper = to_frac_q8(longint'(m_max_fan) << 8);

        if (k == KIND_SEED)
        begin
            // Bumpless start: the seeded integral reproduces the present speed.
            if (m_int == '0)
            begin
                m_integral = 0;
            end
            else
            begin
                m_integral = sat40(to_frac_q8(longint'(pf) << 8) - base - prop - incr);
            end
            return pf;
        end

        if (m_int == '0)
        begin
            m_integral = 0;
        end
        else
        begin
            m_integral = sat40(m_integral + incr);
        end

        // The upper limit is tested first, so with max below min an output above max yields max, any other min.
        outv = base + prop + m_integral;
        if (outv > upper)
        begin
            if (m_int != '0)
            begin
                m_integral = sat40(m_integral - (outv - upper));
            end
            outv = upper;
        end
        else if (outv < base)
        begin
            if (m_int != '0)
            begin
                m_integral = sat40(m_integral + (base - outv));
            end
            outv = base;
        end
        outv = (outv + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        return outv[FAN_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [FAN_W-1:0] got,
                                   input logic [FAN_W-1:0] want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Writes happen only once the core has returned every pending beat.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        in_valid <= 1'b0;
        @(negedge clk);
        while (fan_q.size() != 0 || in_stall)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TARGET_TEMP: m_target  = val[TEMP_W-1:0];
            REG_MIN_FAN:     m_min_fan = val[FAN_W-1:0];
            REG_MAX_FAN:     m_max_fan = val[FAN_W-1:0];
            REG_PROP_GAIN:   m_prop    = val[GAIN_W-1:0];
            REG_INT_GAIN:    m_int     = val[GAIN_W-1:0];
            REG_TIME_STEP:   m_step    = val[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_beat(input logic k, input logic [TEMP_W-1:0] t,
                             input logic [FAN_W-1:0] pf, input logic typed,
                             input logic [FAN_W-1:0] typed_fan);
        logic [FAN_W-1:0] predicted;
        @(posedge clk);
        while (roll(IDLE_SEND))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        temperature <= t;
        present_fan <= pf;
        // Inputs and outputs are settled at the falling edge, so the beat
        // is known to be taken at the next rising edge.
        @(negedge clk);
        while (in_stall)
        begin
            @(negedge clk);
        end
        predicted = predict_fan(k, t, pf);
        fan_q.push_back(typed ? typed_fan : predicted);
    endtask

    always @(posedge clk)
    begin
        out_stall <= roll(IDLE_RECV);
    end

    initial
    begin : result_monitor
        logic             take;
        logic [FAN_W-1:0] seen;
        logic [FAN_W-1:0] want;
        forever
        begin
            @(negedge clk);
            take = rst_n && out_valid && !out_stall;
            seen = fan_speed;
            @(posedge clk);
            if (take)
            begin
                if (fan_q.size() == 0)
                begin
                    report_mismatch("fan_speed beat with nothing pending", seen, '0);
                end
                else
                begin
                    want = fan_q.pop_front();
                    if (seen !== want)
                    begin
                        report_mismatch("fan_speed", seen, want);
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        int                tv;
        int                v_target;
        int                v_min;
        int                v_max;
        int                v_prop;
        int                v_int;
        int                v_step;
        logic              k;
        logic [TEMP_W-1:0] t;
        logic [FAN_W-1:0]  pf;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        idle_mode = IDLE_BOTH;
        foreach (dir_table[r])
        begin
            if (dir_table[r].op == ROW_CFG)
            begin
                write_reg(dir_table[r].idx, dir_table[r].data);
            end
            else
            begin
                send_beat(dir_table[r].kind, dir_table[r].temp, dir_table[r].present,
                          dir_table[r].typed, dir_table[r].fan);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    v_target = int'(RST_TARGET_TEMP);
                    v_min    = int'(RST_MIN_FAN);
                    v_max    = int'(RST_MAX_FAN);
                    v_prop   = int'(RST_PROP_GAIN);
                    v_int    = int'(RST_INT_GAIN);
                    v_step   = int'(RST_TIME_STEP);
                end
                1:
                begin
                    v_target = 255;
                    v_min    = 0;
                    v_max    = 100;
                    v_prop   = 65535;
                    v_int    = 65535;
                    v_step   = 65535;
                end
                2:
                begin
                    v_target = 0;
                    v_min    = 100;
                    v_max    = 0;
                    v_prop   = 0;
                    v_int    = 0;
                    v_step   = 0;
                end
                default:
                begin
                    v_target = $urandom_range(0, 255);
                    v_min    = $urandom_range(0, 60);
                    v_max    = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 100)
                                                            : $urandom_range(v_min, 100);
                    v_prop   = ($urandom_range(0, 99) < 30) ? $urandom_range(0, 65535)
                                                            : $urandom_range(0, 1024);
                    if ($urandom_range(0, 99) < 15)
                    begin
                        v_int = 0;
                    end
                    else if ($urandom_range(0, 99) < 20)
                    begin
                        v_int = $urandom_range(0, 65535);
                    end
                    else
                    begin
                        v_int = $urandom_range(1, 256);
                    end
                    v_step   = ($urandom_range(0, 99) < 20) ? $urandom_range(0, 65535)
                                                            : $urandom_range(64, 512);
                end
            endcase
            write_reg(REG_TARGET_TEMP, CFG_W'(v_target));
            write_reg(REG_MIN_FAN,     CFG_W'(v_min));
            write_reg(REG_MAX_FAN,     CFG_W'(v_max));
            write_reg(REG_PROP_GAIN,   CFG_W'(v_prop));
            write_reg(REG_INT_GAIN,    CFG_W'(v_int));
            write_reg(REG_TIME_STEP,   CFG_W'(v_step));

            @(negedge clk);
            idle_mode = idle_mode_t'(ph % 4);

            // Mostly regulation beats, with some seeds, near the setpoint, where the
            // controller leaves the clamps; the rest spans the full range.
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                k = ($urandom_range(0, 99) < 12) ? KIND_SEED : KIND_STEP;
                if ($urandom_range(0, 9) < 7)
                begin
                    tv = int'(m_target) + int'($urandom_range(0, 40)) - 20;
                    if (tv < 0)
                    begin
                        tv = 0;
                    end
                    if (tv > 255)
                    begin
                        tv = 255;
                    end
                end
                else
                begin
                    tv = $urandom_range(0, 255);
                end
                t  = TEMP_W'(tv);
                pf = FAN_W'($urandom_range(0, 100));
                send_beat(k, t, pf, 1'b0, '0);
            end
        end

        @(posedge clk);
        in_valid <= 1'b0;
        for (int n = 0; n < 5000 && fan_q.size() != 0; n++)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fan_q.size() != 0)
        begin
            report_mismatch("fan_speed beats never returned", '0, fan_q[0]);
        end
        if (error_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin : watchdog
        #400_000;
        $display("TIMEOUT with %0d fan_speed beats pending", fan_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
src/pfsc_pkg.sv
src/pfsc_arith.sv
src/pi_fan_speed_controller_core.sv
verif/tb_pi_fan_speed_controller_core.sv
